>>> src/b64enc_pkg.sv
// Shared types, constants and the sextet-to-character function of the Base64 stream encoder.
package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CharsMax   = 4;

  localparam logic [7:0] PadChar = 8'd61;

  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [CharsMax-1:0][7:0] chars;
    logic [1:0]               last_idx;
    logic                     last_flag;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd97 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'd48 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

>>> src/b64enc_front.sv
// Front end: accepts message bytes, tracks the group phase and builds character jobs.
module b64enc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 q_full,
  input  b64enc_pkg::in_item_t byte_item,
  output logic                 job_push,
  output b64enc_pkg::job_t     job
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;
  logic [7:0] b;
  logic       fin;

  assign job_push = push && !q_full;
  assign b        = byte_item.data_byte;
  assign fin      = byte_item.end_of_message;

  always_comb begin
    job           = '0;
    phase_next    = phase;
    leftover_next = leftover;
    case (phase)
      b64enc_pkg::PhaseSecond: begin
        job.chars[0] = b64enc_pkg::sextet_char({leftover[1:0], b[7:4]});
        if (fin) begin
          job.chars[1]  = b64enc_pkg::sextet_char({b[3:0], 2'b00});
          job.chars[2]  = b64enc_pkg::PadChar;
          job.last_idx  = 2'd2;
          job.last_flag = 1'b1;
        end else begin
          leftover_next = b[3:0];
          phase_next    = b64enc_pkg::PhaseThird;
        end
      end
      b64enc_pkg::PhaseThird: begin
        job.chars[0]  = b64enc_pkg::sextet_char({leftover, b[7:6]});
        job.chars[1]  = b64enc_pkg::sextet_char(b[5:0]);
        job.last_idx  = 2'd1;
        job.last_flag = fin;
        leftover_next = 4'd0;
        phase_next    = b64enc_pkg::PhaseFirst;
      end
      default: begin
        job.chars[0] = b64enc_pkg::sextet_char(b[7:2]);
        if (fin) begin
          job.chars[1]  = b64enc_pkg::sextet_char({b[1:0], 4'b0000});
          job.chars[2]  = b64enc_pkg::PadChar;
          job.chars[3]  = b64enc_pkg::PadChar;
          job.last_idx  = 2'd3;
          job.last_flag = 1'b1;
        end else begin
          leftover_next = {2'b00, b[1:0]};
          phase_next    = b64enc_pkg::PhaseSecond;
        end
      end
    endcase
    if (fin) begin
      phase_next    = b64enc_pkg::PhaseFirst;
      leftover_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= b64enc_pkg::PhaseFirst;
      leftover <= 4'd0;
    end else if (job_push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("Group phase left its range.");

  a_fin_restarts: assert property (@(posedge clk) disable iff (rst)
    job_push && fin |=> phase == b64enc_pkg::PhaseFirst && leftover == 4'd0)
    else $error("Final byte did not restart the group.");

  a_partial_leftover: assert property (@(posedge clk) disable iff (rst)
    phase == b64enc_pkg::PhaseSecond |-> leftover[3:2] == 2'b00)
    else $error("Leftover bits too wide after the first byte of a group.");

endmodule

>>> src/b64enc_queue.sv
// Short job queue between the front end and the character serializer.
module b64enc_queue #(
  parameter int unsigned DEPTH = b64enc_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  b64enc_pkg::job_t wr_job,
  output logic             q_full,
  input  logic             rd_en,
  output logic             q_empty,
  output b64enc_pkg::job_t rd_job
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  b64enc_pkg::job_t slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CntW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("Job queue count overflowed.");

endmodule

>>> src/b64enc_back.sv
// Back end: walks the characters of each job into the result register.
module b64enc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  b64enc_pkg::job_t      q_job,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output b64enc_pkg::out_item_t char_item
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign empty  = !out_valid;
  assign load   = !q_empty && (!out_valid || pop);
  assign at_end = (idx == q_job.last_idx);
  assign q_pop  = load && at_end;

  always_ff @(posedge clk) begin
    if (load) begin
      char_item.out_char <= q_job.chars[idx];
      char_item.out_last <= at_end && q_job.last_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx <= q_job.last_idx)
    else $error("Character index ran past the end of the job.");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> idx == 2'd0)
    else $error("Character index not cleared between jobs.");

endmodule

>>> src/base64_stream_encoder_unit.sv
// Top level of the streaming Base64 encoder.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+---------------------------------
//   bytes    | in        | push / full      | byte_item (data_byte, end_of_message)
//   chars    | out       | pop / empty      | char_item (out_char, out_last)
//
// One character leaves per cycle while pop is high and jobs wait in the queue; a byte
// produces one or two characters, and two to four on a final byte.
// The character serializer in the back end sets that rate.
// An accepted byte becomes a job in the queue at the edge that accepts it; its first
// character is loaded into char_item in its turn. Reset clears phase, queue
// and out_valid. When pop is held low the queue fills and full rises; bytes then wait.
module base64_stream_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = b64enc_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  b64enc_pkg::in_item_t  byte_item,
  output logic                  empty,
  input  logic                  pop,
  output b64enc_pkg::out_item_t char_item
);

  logic             job_push;
  b64enc_pkg::job_t job;
  logic             q_empty;
  logic             q_pop;
  b64enc_pkg::job_t q_job;

  b64enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (full),
    .byte_item (byte_item),
    .job_push  (job_push),
    .job       (job)
  );

  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job),
    .q_full  (full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_job  (q_job)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .char_item (char_item)
  );

endmodule

>>> dv/base64_stream_encoder_unit_test.sv
// Self-checking testbench for the streaming Base64 encoder: directed table, then random messages.
`timescale 1ns / 100ps

module base64_stream_encoder_unit_test;

  typedef struct {
    logic [7:0]  data;
    logic        eom;
    int          nchars;
    logic [31:0] text;
  } byte_row_t;

  localparam int RowCount    = 22;
  localparam int RandomCount = 108;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic                  full;
  logic                  empty;
  b64enc_pkg::in_item_t  byte_item = '0;
  b64enc_pkg::out_item_t char_item;

  string     b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [1:0] group_pos = b64enc_pkg::PhaseFirst;
  logic [3:0] carry_bits = 4'd0;
  b64enc_pkg::out_item_t predicted_chars [4];
  b64enc_pkg::out_item_t expected_chars [$];

  int   mismatch_count = 0;
  logic steady = 1'b0;
  logic stall_request = 1'b0;

  byte_row_t byte_table [RowCount] = '{
    '{8'h00, 1'b1, 4, "AA=="},
    '{8'hFF, 1'b1, 4, "/w=="},
    '{8'h00, 1'b0, 1, "A"},
    '{8'h00, 1'b0, 1, "A"},
    '{8'h00, 1'b1, 2, "AA"},
    '{8'hFF, 1'b0, 1, "/"},
    '{8'hFF, 1'b0, 1, "/"},
    '{8'hFF, 1'b1, 2, "//"},
    '{8'h00, 1'b0, 1, "A"},
    '{8'h00, 1'b1, 3, "AA="},
    '{8'hFF, 1'b0, 1, "/"},
    '{8'hFF, 1'b1, 3, "/8="},
    '{8'h4D, 1'b0, 0, 32'd0},
    '{8'h61, 1'b0, 0, 32'd0},
    '{8'h6E, 1'b1, 0, 32'd0},
    '{8'h80, 1'b1, 0, 32'd0},
    '{8'h01, 1'b0, 0, 32'd0},
    '{8'h7F, 1'b1, 0, 32'd0},
    '{8'hA5, 1'b0, 0, 32'd0},
    '{8'h5A, 1'b0, 0, 32'd0},
    '{8'hC3, 1'b0, 0, 32'd0},
    '{8'h3C, 1'b1, 0, 32'd0}
  };

  base64_stream_encoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .empty     (empty),
    .pop       (pop),
    .char_item (char_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return b64_alphabet[v];
  endfunction

  function automatic int encode_byte(input b64enc_pkg::in_item_t it);
    logic [7:0] b;
    int         n;
    b = it.data_byte;
    n = 0;
    case (group_pos)
      b64enc_pkg::PhaseSecond: begin
        predicted_chars[0] = '{b64_char({carry_bits[1:0], b[7:4]}), 1'b0};
        if (it.end_of_message) begin
          predicted_chars[1] = '{b64_char({b[3:0], 2'b00}), 1'b0};
          predicted_chars[2] = '{b64enc_pkg::PadChar, 1'b1};
          n = 3;
        end else begin
          carry_bits = b[3:0];
          group_pos = b64enc_pkg::PhaseThird;
          n = 1;
        end
      end
      b64enc_pkg::PhaseThird: begin
        predicted_chars[0] = '{b64_char({carry_bits, b[7:6]}), 1'b0};
        predicted_chars[1] = '{b64_char(b[5:0]), it.end_of_message};
        carry_bits = 4'd0;
        group_pos = b64enc_pkg::PhaseFirst;
        n = 2;
      end
      default: begin
        predicted_chars[0] = '{b64_char(b[7:2]), 1'b0};
        if (it.end_of_message) begin
          predicted_chars[1] = '{b64_char({b[1:0], 4'b0000}), 1'b0};
          predicted_chars[2] = '{b64enc_pkg::PadChar, 1'b0};
          predicted_chars[3] = '{b64enc_pkg::PadChar, 1'b1};
          n = 4;
        end else begin
          carry_bits = {2'b00, b[1:0]};
          group_pos = b64enc_pkg::PhaseSecond;
          n = 1;
        end
      end
    endcase
    if (it.end_of_message) begin
      group_pos = b64enc_pkg::PhaseFirst;
      carry_bits = 4'd0;
    end
    return n;
  endfunction

  // A nonzero nchars means the expected characters are given in text.
  task automatic send_byte(input b64enc_pkg::in_item_t it, input int nchars,
                           input logic [31:0] text);
    int                    n;
    b64enc_pkg::out_item_t c;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 24) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    byte_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    n = encode_byte(it);
    if (nchars != 0) begin
      for (int k = 0; k < nchars; k++) begin
        c.out_char = text[(nchars - 1 - k) * 8 +: 8];
        c.out_last = (k == nchars - 1) && it.end_of_message;
        expected_chars.push_back(c);
      end
    end else begin
      for (int k = 0; k < n; k++) expected_chars.push_back(predicted_chars[k]);
    end
  endtask

  initial begin : char_sink
    forever begin
      @(negedge clk);
      if (stall_request && !rst) begin
        stall_request = 1'b0;
        pop <= 1'b0;
        repeat (80) @(negedge clk);
      end
      pop <= !rst && (steady || $urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin : char_check
    b64enc_pkg::out_item_t exp;
    if (!rst && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected item, char %h last %b", $time, char_item.out_char,
                 char_item.out_last);
        mismatch_count++;
      end else begin
        exp = expected_chars.pop_front();
        if (char_item.out_char !== exp.out_char) begin
          $display("%0t: out_char expected %h actual %h", $time, exp.out_char,
                   char_item.out_char);
          mismatch_count++;
        end
        if (char_item.out_last !== exp.out_last) begin
          $display("%0t: out_last expected %b actual %b", $time, exp.out_last,
                   char_item.out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : byte_source
    b64enc_pkg::in_item_t it;
    int                   random_sent;
    int                   len;
    logic                 stall_done;
    logic                 pause_done;
    random_sent = 0;
    stall_done = 1'b0;
    pause_done = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < RowCount; r++) begin
      it.data_byte = byte_table[r].data;
      it.end_of_message = byte_table[r].eom;
      send_byte(it, byte_table[r].nchars, byte_table[r].text);
    end

    while (random_sent < RandomCount) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int k = 0; k < len && random_sent < RandomCount; k++) begin
        if (!stall_done && random_sent >= 20) begin
          stall_request = 1'b1;
          stall_done = 1'b1;
        end
        if (!pause_done && random_sent >= 60) begin
          @(negedge clk);
          push <= 1'b0;
          while (expected_chars.size() != 0) @(posedge clk);
          pause_done = 1'b1;
        end
        steady = (random_sent >= 75) && (random_sent < 105);
        it.data_byte = $urandom;
        it.end_of_message = (k == len - 1) || (random_sent == RandomCount - 1);
        send_byte(it, 0, 32'd0);
        random_sent++;
      end
    end

    @(negedge clk);
    push <= 1'b0;
    steady = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
